// File: rtl/mheap_pkg.sv
// ----------------------------------------------------------------------------
// mheap_pkg
// Shared types and constants of the binary max-heap block.
// ----------------------------------------------------------------------------
package mheap_pkg;

    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int HEAP_DEPTH_DEF = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SWAP_RD,
        S_SWAP_WR,
        S_RB_START,
        S_SD_RDN,
        S_SD_GOTN,
        S_SD_GOTL,
        S_SD_GOTR,
        S_SD_DECIDE,
        S_SD_SWAP2,
        S_SD_NEXT,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } t_state;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } t_result;

endpackage

// File: rtl/mheap_if.sv
// ----------------------------------------------------------------------------
// mheap_if
// Valid/ready channels of the heap block: command in, result out.
// ----------------------------------------------------------------------------
interface mheap_in_if import mheap_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mheap_out_if import mheap_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output top_value, output count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input count, input status,
                    output ready);
endinterface

// File: rtl/mheap_ram.sv
// ----------------------------------------------------------------------------
// mheap_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mheap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mheap_ctrl.sv
// ----------------------------------------------------------------------------
// mheap_ctrl
// Command sequencer: linear search, swap with last, bottom-up rebuild by
// sift-down, all through one read and one write port of the heap RAM.
// ----------------------------------------------------------------------------
module mheap_ctrl import mheap_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic signed [DATA_W-1:0]      i_value,
    input  logic                          i_out_free,
    output t_result                       o_res,
    output logic                          o_we,
    output logic [$clog2(HEAP_DEPTH)-1:0] o_waddr,
    output logic [DATA_W-1:0]             o_wdata,
    output logic [$clog2(HEAP_DEPTH)-1:0] o_raddr,
    input  logic [DATA_W-1:0]             i_rdata
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_found, n_found;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_node, n_node;
    logic [AW-1:0]     r_big, n_big;
    logic [DATA_W-1:0] r_nval, n_nval;
    logic [DATA_W-1:0] r_bval, n_bval;
    logic [DATA_W-1:0] r_top, n_top;
    t_status           r_status, n_status;

    logic          accept;
    logic          is_full;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] half;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] l_node, rch_node, l_big;
    logic          l_ok, rch_ok, lb_ok;
    logic          hit;
    logic          idx_last;
    logic          gt_rd;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_full  = r_cnt >= CW'(HEAP_DEPTH);
    assign cnt_m1   = r_cnt - CW'(1);
    assign half     = r_cnt >> 1;
    assign cnt_x    = XW'(r_cnt);
    assign l_node   = {1'b0, r_node, 1'b1};
    assign rch_node = l_node + XW'(1);
    assign l_big    = {1'b0, r_big, 1'b1};
    assign l_ok     = l_node < cnt_x;
    assign rch_ok   = rch_node < cnt_x;
    assign lb_ok    = l_big < cnt_x;
    assign hit      = i_rdata == r_val;
    assign idx_last = CW'(r_idx) == cnt_m1;
    assign gt_rd    = $signed(i_rdata) > $signed(r_bval);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        n_state = is_full ? S_TOP_RD : S_RB_START;
                    end else begin
                        n_state = (r_cnt == '0) ? S_TOP_RD : S_SEARCH_RD;
                    end
                end
            end
            S_SEARCH_RD:  n_state = S_SEARCH_CMP;
            S_SEARCH_CMP: begin
                priority if (hit)  n_state = S_SWAP_RD;
                else if (idx_last) n_state = S_TOP_RD;
                else               n_state = S_SEARCH_RD;
            end
            S_SWAP_RD:    n_state = S_SWAP_WR;
            S_SWAP_WR:    n_state = S_RB_START;
            S_RB_START:   n_state = (half == '0) ? S_TOP_RD : S_SD_RDN;
            S_SD_RDN:     n_state = S_SD_GOTN;
            S_SD_GOTN:    n_state = l_ok ? S_SD_GOTL : S_SD_NEXT;
            S_SD_GOTL:    n_state = rch_ok ? S_SD_GOTR : S_SD_DECIDE;
            S_SD_GOTR:    n_state = S_SD_DECIDE;
            S_SD_DECIDE:  n_state = (r_big == r_node) ? S_SD_NEXT : S_SD_SWAP2;
            S_SD_SWAP2:   n_state = lb_ok ? S_SD_GOTL : S_SD_NEXT;
            S_SD_NEXT:    n_state = (r_k == '0) ? S_TOP_RD : S_SD_RDN;
            S_TOP_RD:     n_state = S_TOP_WAIT;
            S_TOP_WAIT:   n_state = S_OUT;
            S_OUT:        n_state = i_out_free ? S_IDLE : S_OUT;
            default:      n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cnt    = r_cnt;
        n_val    = r_val;
        n_idx    = r_idx;
        n_found  = r_found;
        n_k      = r_k;
        n_node   = r_node;
        n_big    = r_big;
        n_nval   = r_nval;
        n_bval   = r_bval;
        n_top    = r_top;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = '0;
        o_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val    = i_value;
                    n_idx    = '0;
                    n_status = ST_OK;
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            // append at the end
                            o_we    = 1'b1;
                            o_waddr = AW'(r_cnt);
                            o_wdata = i_value;
                            n_cnt   = r_cnt + CW'(1);
                        end
                    end else if (r_cnt == '0) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_SEARCH_RD: begin
                o_raddr = r_idx;
            end
            S_SEARCH_CMP: begin
                priority if (hit) begin
                    n_found = r_idx;
                end else if (idx_last) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_SWAP_RD: begin
                o_raddr = AW'(cnt_m1);
            end
            S_SWAP_WR: begin
                // last entry moves into the hole; the old one drops off the end
                o_we    = 1'b1;
                o_waddr = r_found;
                o_wdata = i_rdata;
                n_cnt   = cnt_m1;
            end
            S_RB_START: begin
                n_k    = AW'(half - CW'(1));
                n_node = AW'(half - CW'(1));
            end
            S_SD_RDN: begin
                o_raddr = r_node;
            end
            S_SD_GOTN: begin
                n_nval  = i_rdata;
                n_bval  = i_rdata;
                n_big   = r_node;
                o_raddr = AW'(l_node);
            end
            S_SD_GOTL: begin
                if (gt_rd) begin
                    n_big  = AW'(l_node);
                    n_bval = i_rdata;
                end
                o_raddr = AW'(rch_node);
            end
            S_SD_GOTR: begin
                if (gt_rd) begin
                    n_big  = AW'(rch_node);
                    n_bval = i_rdata;
                end
            end
            S_SD_DECIDE: begin
                if (r_big != r_node) begin
                    o_we    = 1'b1;
                    o_waddr = r_node;
                    o_wdata = r_bval;
                end
            end
            S_SD_SWAP2: begin
                // finish the swap and descend; node value stays in r_nval
                o_we    = 1'b1;
                o_waddr = r_big;
                o_wdata = r_nval;
                n_node  = r_big;
                n_bval  = r_nval;
                o_raddr = AW'(l_big);
            end
            S_SD_NEXT: begin
                n_k    = r_k - AW'(1);
                n_node = r_k - AW'(1);
            end
            S_TOP_RD: begin
                o_raddr = '0;
            end
            S_TOP_WAIT: begin
                n_top = (r_cnt != '0) ? i_rdata : '0;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_k      <= n_k;
        r_node   <= n_node;
        r_big    <= n_big;
        r_nval   <= n_nval;
        r_bval   <= n_bval;
        r_top    <= n_top;
        r_status <= n_status;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res.done      = (r_state == S_OUT) && i_out_free;
    assign o_res.top_value = r_top;
    assign o_res.count     = COUNT_W'(r_cnt);
    assign o_res.status    = r_status;

endmodule

// File: rtl/max_heap_insert_delete_top.sv
// ----------------------------------------------------------------------------
// max_heap_insert_delete_top
// Binary max-heap of signed 32-bit values with insert and delete commands.
// ----------------------------------------------------------------------------
// Each command beat yields one result beat: top value (0 when empty), count
// and status (ok, full, not found). The block takes one command at a time;
// the heap sits in a single RAM with one read and one write port, and that
// read port sets the latency. An insert appends the value and then rebuilds
// the heap bottom-up by sift-down; a delete scans for the value, moves the
// last entry into its place and rebuilds (or reports not found), while a
// full insert or a delete on an empty heap only reads the top. A finished
// result waits in an output register, so the next command can be taken
// while it is stalled. No clearing pass is needed after reset.
module max_heap_insert_delete_top import mheap_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mheap_in_if.sink     i_in,
    mheap_out_if.source  o_out
);

    localparam int AW = $clog2(HEAP_DEPTH);

    t_result           res;
    logic              out_free;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_top_value;
    logic [COUNT_W-1:0]       r_count;
    logic [STATUS_W-1:0]      r_status;

    assign out_free = !r_out_valid || o_out.ready;

    mheap_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_cmd      (i_in.cmd),
        .i_value    (i_in.value),
        .i_out_free (out_free),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    mheap_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register: load a new beat when the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_top_value <= res.top_value;
            r_count     <= res.count;
            r_status    <= res.status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.top_value = r_top_value;
    assign o_out.count     = r_count;
    assign o_out.status    = r_status;

endmodule

// File: rtl/mheap_checker.sv
// ----------------------------------------------------------------------------
// mheap_checker
// Port-level checks of the heap block, bound to the top level.
// ----------------------------------------------------------------------------
module mheap_checker import mheap_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] i_top_value,
    input logic [COUNT_W-1:0]       i_count,
    input logic [STATUS_W-1:0]      i_status
);

    logic [COUNT_W-1:0] r_last_cnt;

    // count carried by the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_cnt <= i_count;
        end
    end

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> i_count == COUNT_W'(HEAP_DEPTH))
        else $error("full status with heap not at capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HEAP_DEPTH < 32) && i_out_valid && (i_count == '0) |-> i_top_value == '0)
        else $error("empty heap reports nonzero top value");

    a_unchanged_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == ST_FULL) || (i_status == ST_NOT_FOUND))
        |-> i_count == r_last_cnt)
        else $error("rejected command changed the count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK) || (i_status == ST_FULL)
                        || (i_status == ST_NOT_FOUND))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_top_value)
                                        && $stable(i_count) && $stable(i_status))
        else $error("stalled result beat changed");

endmodule

bind max_heap_insert_delete_top mheap_checker #(
    .HEAP_DEPTH (HEAP_DEPTH)
) u_mheap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_top_value (o_out.top_value),
    .i_count     (o_out.count),
    .i_status    (o_out.status)
);

// File: bench/max_heap_insert_delete_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_insert_delete_top_tb
// Self-checking bench for the binary max-heap insert/delete block.
// ----------------------------------------------------------------------------
// A directed run covers the value extremes, the empty heap, duplicates, a
// full heap and deletes of absent values. A random run follows, mostly
// inserts and deletes of held values, with phases that fill and drain the
// heap. A scoreboard keeps its own copy of the heap, works out the result
// of each accepted command and checks each result beat against it. Both
// channels idle and stall in random bursts, except near the end.
// ----------------------------------------------------------------------------
module max_heap_insert_delete_top_tb;
    import mheap_pkg::*;

    localparam int DEPTH        = HEAP_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 1200000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } heap_result_t;

    class heap_scoreboard;
        logic signed [DATA_W-1:0] heap_entries[DEPTH];
        int                       held_count;
        heap_result_t             expected_results[$];
        int                       mismatch_count;

        function new();
            held_count     = 0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(string what);
            $display("tb: mismatch at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        function void sift_down(int n, int node);
            int                       big;
            int                       l;
            int                       r;
            logic signed [DATA_W-1:0] t;
            forever begin
                big = node;
                l   = 2 * node + 1;
                r   = 2 * node + 2;
                if (l < n && heap_entries[l] > heap_entries[big]) big = l;
                if (r < n && heap_entries[r] > heap_entries[big]) big = r;
                if (big == node) return;
                t                  = heap_entries[node];
                heap_entries[node] = heap_entries[big];
                heap_entries[big]  = t;
                node               = big;
            end
        endfunction

        function void rebuild_heap(int n);
            for (int k = n / 2 - 1; k >= 0; k--) sift_down(n, k);
        endfunction

        // work out the result of one accepted command beat
        function void note_command(t_cmd cmd, logic signed [DATA_W-1:0] value);
            heap_result_t             res;
            int                       found;
            logic signed [DATA_W-1:0] t;
            res.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    heap_entries[held_count] = value;
                    held_count++;
                    rebuild_heap(held_count);
                end
            end else begin
                found = held_count;
                for (int i = 0; i < held_count; i++) begin
                    if (heap_entries[i] == value) begin
                        found = i;
                        break;
                    end
                end
                if (found >= held_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    t                            = heap_entries[found];
                    heap_entries[found]          = heap_entries[held_count - 1];
                    heap_entries[held_count - 1] = t;
                    held_count--;
                    rebuild_heap(held_count);
                end
            end
            res.top_value = (held_count > 0) ? heap_entries[0] : '0;
            res.count     = COUNT_W'(held_count);
            expected_results.push_back(res);
        endfunction

        task check_result(logic signed [DATA_W-1:0] top_value, logic [COUNT_W-1:0] count,
                          logic [STATUS_W-1:0] status);
            heap_result_t exp_res;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected (top %0d count %0d)",
                                          top_value, count));
                return;
            end
            exp_res = expected_results.pop_front();
            if (top_value !== exp_res.top_value)
                report_mismatch($sformatf("top_value %0d, expected %0d",
                                          top_value, exp_res.top_value));
            if (count !== exp_res.count)
                report_mismatch($sformatf("count %0d, expected %0d", count, exp_res.count));
            if (status !== exp_res.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          status, exp_res.status));
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        function logic signed [DATA_W-1:0] pick_held();
            return heap_entries[$urandom_range(0, held_count - 1)];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet_tail = 1'b0;
    int   cycle_count = 0;

    heap_scoreboard sb = new();

    mheap_in_if  in_ch();
    mheap_out_if out_ch();

    max_heap_insert_delete_top #(.HEAP_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.top_value, out_ch.count, out_ch.status);
    end

    // stall the result side in bursts
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // drive one command beat and hold it until accepted
    task send_command(t_cmd cmd, logic signed [DATA_W-1:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_command(cmd, value);
    endtask

    function logic signed [DATA_W-1:0] random_insert_value();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
            4:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:    return $urandom;
        endcase
    endfunction

    initial begin
        int fill_bias;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_INSERT;
        in_ch.value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty heap, extremes, duplicates, absent value, full heap
        send_command(CMD_DELETE, 32'sd5);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_DELETE, 32'sd1234);
        send_command(CMD_DELETE, -32'sd1);
        send_command(CMD_DELETE, 32'sh7FFF_FFFF);
        for (int k = 0; k < 13; k++)
            send_command(CMD_INSERT, (k % 3 == 0) ? $signed($urandom) : 32'(k * 1000 - 6000));
        send_command(CMD_INSERT, 32'sd42);
        send_command(CMD_DELETE, 32'sh8000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail <= 1'b1;
            // alternate phases that fill and drain the heap
            fill_bias = ((n / 48) % 2 == 0) ? 75 : 30;
            if ($urandom_range(0, 99) < fill_bias)
                send_command(CMD_INSERT, random_insert_value());
            else if (sb.held_count > 0 && $urandom_range(0, 99) < 80)
                send_command(CMD_DELETE, sb.pick_held());
            else
                send_command(CMD_DELETE, random_insert_value());
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mheap_pkg.sv
rtl/mheap_if.sv
rtl/mheap_ram.sv
rtl/mheap_ctrl.sv
rtl/max_heap_insert_delete_top.sv
rtl/mheap_checker.sv
bench/max_heap_insert_delete_top_tb.sv
